/* sv/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked every clock, held off while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* sv/sols_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sols_pkg;

    // Table size; bounded by the 4-bit slot and 5-bit index fields.
    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int LEN_W = 5;
    localparam int DATA_W = 32;

    localparam logic [1:0] OP_LOAD      = 2'd0;
    localparam logic [1:0] OP_MTF       = 2'd1;
    localparam logic [1:0] OP_TRANSPOSE = 2'd2;
    localparam logic [1:0] OP_NONE      = 2'd3;

    typedef struct packed {
        logic [1:0]               opcode;
        logic [3:0]               slot;
        logic signed [DATA_W-1:0] value;
    } sols_in_t;

    typedef struct packed {
        logic [LEN_W-1:0] found_index;
        logic             found;
    } sols_out_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;     // write one entry this edge
        logic capture;  // compare and latch the search this edge
        logic reorder;  // apply move-to-front / transpose this edge
    } sols_cmd_t;

endpackage

`default_nettype wire

/* sv/sols_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module sols_ctrl
    import sols_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic [1:0] opcode,
    output logic            busy,
    output logic            done,
    output sols_cmd_t       cmd
);

`include "assert_macros.svh"

    typedef enum logic {
        S_IDLE,
        S_MOVE
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;
    logic   accept;
    logic   is_search;

    assign busy      = (state_reg == S_MOVE);
    assign done      = done_reg;
    assign accept    = start && !busy;
    assign is_search = (opcode == OP_MTF) || (opcode == OP_TRANSPOSE);

    always_comb
    begin
        cmd.load    = accept && (opcode == OP_LOAD);
        cmd.capture = accept && is_search;
        cmd.reorder = (state_reg == S_MOVE);
        state_next  = state_reg;
        done_next   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && is_search)
                begin
                    state_next = S_MOVE;
                    done_next  = 1'b1;
                end
            end
            S_MOVE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    `ASSERT_CLK(a_done_after_search,
        done |-> $past(start && !busy && (opcode == OP_MTF || opcode == OP_TRANSPOSE)),
        "result strobe without an accepted search")
    `ASSERT_CLK(a_done_single, done |=> !done, "result strobe longer than one cycle")

endmodule

`default_nettype wire

/* sv/sols_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module sols_datapath
    import sols_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire sols_cmd_t        cmd,
    input  wire sols_in_t         item,
    input  wire logic             cfg_we,
    input  wire logic [LEN_W-1:0] cfg_wdata,
    output sols_out_t             result
);

`include "assert_macros.svh"

    logic [DATA_W-1:0] cells_reg [DEPTH];
    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  eff_len;
    logic [DEPTH-1:0]  match;
    logic              hit;
    logic [LEN_W-1:0]  pos;
    logic              hit_reg;
    logic [LEN_W-1:0]  pos_reg;
    logic              mtf_reg;
    logic [DATA_W-1:0] target_reg;

    // Lengths past the table saturate.
    assign eff_len = (len_reg > LEN_W'(DEPTH)) ? LEN_W'(DEPTH) : len_reg;

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            match[i] = (LEN_W'(i) < eff_len) && (cells_reg[i] == item.value);
        end
    end

    // First match wins; a miss reports the used length.
    always_comb
    begin
        hit = 1'b0;
        pos = eff_len;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hit = 1'b1;
                pos = LEN_W'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else if (cfg_we)
        begin
            len_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            hit_reg    <= hit;
            pos_reg    <= pos;
            mtf_reg    <= (item.opcode == OP_MTF);
            target_reg <= item.value;
        end
    end

    // On a reorder each cell reads only its lower neighbor; the moved value is the target.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                cells_reg[i] <= '0;
            end
        end
        else if (cmd.load)
        begin
            if (LEN_W'(item.slot) < LEN_W'(DEPTH))
            begin
                cells_reg[IDX_W'(item.slot)] <= item.value;
            end
        end
        else if (cmd.reorder && hit_reg && (pos_reg != '0))
        begin
            if (mtf_reg)
            begin
                cells_reg[0] <= target_reg;
                for (int i = 1; i < DEPTH; i++)
                begin
                    if (LEN_W'(i) <= pos_reg)
                    begin
                        cells_reg[i] <= cells_reg[i-1];
                    end
                end
            end
            else
            begin
                for (int i = 0; i < DEPTH; i++)
                begin
                    if (LEN_W'(i + 1) == pos_reg)
                    begin
                        cells_reg[i] <= target_reg;
                    end
                end
                for (int i = 1; i < DEPTH; i++)
                begin
                    if (LEN_W'(i) == pos_reg)
                    begin
                        cells_reg[i] <= cells_reg[i-1];
                    end
                end
            end
        end
    end

    assign result.found_index = pos_reg;
    assign result.found       = hit_reg;

    `ASSERT_CLK(a_hit_in_range, (cmd.reorder && hit_reg) |-> (pos_reg < eff_len),
        "hit index outside used list")
    `ASSERT_CLK(a_miss_index, (cmd.reorder && !hit_reg) |-> (pos_reg == eff_len),
        "miss must report the used length")
    `ASSERT_CLK(a_mtf_front, (cmd.reorder && hit_reg && mtf_reg) |=>
        (cells_reg[0] == $past(target_reg)), "move-to-front left wrong head entry")

endmodule

`default_nettype wire

/* sv/self_organizing_list_search.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                  Direction  Handshake
// -------   --------------------   ---------  ---------------------------------
// item      start, item, busy      in         taken when start && !busy
// result    done, result           out        valid for the one cycle done is high
// config    cfg_we, cfg_wdata      in         list length written when cfg_we
//
// For a load (or an unused opcode), busy stays low.
// For a search, the compare and first-match pick run in the accept cycle, and
// the shift or swap lands at the end of the next cycle while done is high.
// busy is high only while the shift or swap is applied; the receiver cannot stall.
// Async active-low reset clears the table and the list length to zero.

module self_organizing_list_search
    import sols_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire sols_in_t         item,
    output logic                  done,
    output sols_out_t             result,
    input  wire logic             cfg_we,
    input  wire logic [LEN_W-1:0] cfg_wdata
);

    sols_cmd_t cmd;

    // Sequencer: idle / reorder.
    sols_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (item.opcode),
        .busy   (busy),
        .done   (done),
        .cmd    (cmd)
    );

    // Entry cells, parallel compare, priority pick and neighbor shift.
    sols_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .result    (result)
    );

endmodule

`default_nettype wire

/* dv/sols_checker.sv */
`timescale 1ns / 1ps

// Watches the item, result and config channels of the list search block,
// keeps a shadow table and predicts every search result.
module sols_checker
    import sols_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  sols_in_t         item,
    input  logic             done,
    input  sols_out_t        result,
    input  logic             cfg_we,
    input  logic [LEN_W-1:0] cfg_wdata,
    output int               mismatches,
    output int               outstanding
);

    logic [DATA_W-1:0] shadow_table [DEPTH];
    logic [LEN_W-1:0]  shadow_len;
    sols_out_t         search_results [$];

    task automatic flag_error(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t ns: %s", $time, msg);
    endtask

    // Scan, pick the first match, then reorder the shadow table.
    task automatic lookup_and_reorder(input sols_in_t it);
        int                span;
        int                pos;
        int                k;
        logic              hit;
        logic [DATA_W-1:0] moved;
        sols_out_t         want;

        if (it.opcode == OP_LOAD) begin
            shadow_table[it.slot] = it.value;
            return;
        end
        if (it.opcode == OP_NONE)
            return;

        // list length saturates at the table depth
        span = (shadow_len > DEPTH) ? DEPTH : int'(shadow_len);
        hit  = 1'b0;
        pos  = span;
        for (k = 0; k < span; k++) begin
            if (!hit && shadow_table[k] == it.value) begin
                hit = 1'b1;
                pos = k;
            end
        end

        if (hit && pos > 0) begin
            moved = shadow_table[pos];
            if (it.opcode == OP_MTF) begin
                for (k = pos; k > 0; k--)
                    shadow_table[k] = shadow_table[k-1];
                shadow_table[0] = moved;
            end
            else begin
                shadow_table[pos]   = shadow_table[pos-1];
                shadow_table[pos-1] = moved;
            end
        end

        want.found_index = pos[LEN_W-1:0];
        want.found       = hit;
        search_results.push_back(want);
    endtask

    task automatic compare_result(input sols_out_t got);
        sols_out_t want;

        if (search_results.size() == 0) begin
            flag_error($sformatf("result with nothing pending: index %0d found %0b",
                                 got.found_index, got.found));
            return;
        end
        want = search_results.pop_front();
        if (got.found_index !== want.found_index)
            flag_error($sformatf("found_index: expected %0d, got %0d",
                                 want.found_index, got.found_index));
        if (got.found !== want.found)
            flag_error($sformatf("found: expected %0b, got %0b", want.found, got.found));
    endtask

    always @(posedge clk or negedge rst_n) begin
        int k;
        if (!rst_n) begin
            for (k = 0; k < DEPTH; k++)
                shadow_table[k] = '0;
            shadow_len = '0;
            search_results.delete();
            mismatches = 0;
        end
        else begin
            if (done)
                compare_result(result);
            // an item taken on the same edge as a length write sees the old length
            if (start && !busy)
                lookup_and_reorder(item);
            if (cfg_we)
                shadow_len = cfg_wdata;
        end
        outstanding = search_results.size();
    end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

// Stimulus and verdict for the self-organizing list search block.
// All checking lives in sols_checker; this module drives items and config,
// and reads back the mismatch and outstanding counts.
module tb_top
    import sols_pkg::*;
();

    logic             clk = 1'b0;
    logic             rst_n;
    logic             start;
    logic             busy;
    sols_in_t         item_in;
    logic             done;
    sols_out_t        result_out;
    logic             cfg_we;
    logic [LEN_W-1:0] cfg_wdata;
    int               mismatches;
    int               outstanding;

    // 20 ns period
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    self_organizing_list_search DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item_in),
        .done      (done),
        .result    (result_out),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    sols_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .item        (item_in),
        .done        (done),
        .result      (result_out),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    function automatic sols_in_t make_item(input logic [1:0] op, input logic [3:0] s,
                                           input logic [DATA_W-1:0] v);
        sols_in_t it;
        it.opcode = op;
        it.slot   = s;
        it.value  = v;
        return it;
    endfunction

    // Present one item from the falling edge; it is taken at the first rising
    // edge with busy low. start stays high until the caller's next action.
    task automatic send(input sols_in_t it);
        @(negedge clk);
        start   = 1'b1;
        item_in = it;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Sender gap with start held low; n sets its length.
    task automatic pause(input int n);
        repeat (n) begin
            @(negedge clk);
            start = 1'b0;
        end
    endtask

    // Hold off until every search result is in. Loads give no result, so
    // trailing idle cycles cover a search still in flight behind them.
    task automatic drain();
        @(negedge clk);
        start = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    // list_length writes only with the block idle.
    task automatic set_length(input logic [LEN_W-1:0] len);
        drain();
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = len;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // Timeout: well past the slowest legal run (~900 items plus gaps).
    initial begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        logic [DATA_W-1:0] pool [8];
        logic [LEN_W-1:0]  phase_len [10];
        logic [1:0]        op;
        logic [DATA_W-1:0] v;
        int                phase;
        int                sent;
        int                fill;
        int                roll;
        int                k;
        bit                gaps;

        rst_n     = 1'b0;
        start     = 1'b0;
        item_in   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // ---------------- directed ----------------
        // Full table with extremes, a duplicate value (first match must win).
        set_length(5'd16);
        for (k = 0; k < DEPTH; k++) begin
            case (k)
                0:       v = 32'h7fff_ffff;
                1, 9:    v = 32'h8000_0000;
                2:       v = 32'h0000_0000;
                3:       v = 32'hffff_ffff;
                default: v = 100 + k;
            endcase
            send(make_item(OP_LOAD, k[3:0], v));
        end
        send(make_item(OP_MTF, 4'd0, 32'h7fff_ffff));        // hit at slot zero, no move
        send(make_item(OP_MTF, 4'd5, 32'h8000_0000));        // slot 1 to front
        send(make_item(OP_TRANSPOSE, 4'd0, 32'd115));        // last slot swaps down
        send(make_item(OP_MTF, 4'd15, 32'd114));             // now at last slot, to front
        send(make_item(OP_TRANSPOSE, 4'd3, 32'h1234_5678));  // miss reports 16
        send(make_item(OP_NONE, 4'd7, 32'hdead_beef));       // unused opcode, no result
        // empty list: every search misses with index 0
        set_length(5'd0);
        send(make_item(OP_TRANSPOSE, 4'd0, 32'h0));
        // length beyond table saturates to DEPTH
        set_length(5'd31);
        send(make_item(OP_MTF, 4'd0, 32'hffff_ffff));
        send(make_item(OP_MTF, 4'd0, 32'h5a5a_a5a5));

        // ---------------- random ----------------
        phase_len[0] = 5'd16;
        phase_len[1] = 5'd5;
        phase_len[2] = 5'd31;
        phase_len[3] = 5'd1;
        phase_len[4] = 5'd2;
        phase_len[5] = 5'd0;
        phase_len[6] = 5'd17;
        phase_len[7] = 5'd9;
        phase_len[8] = 5'd16;
        phase_len[9] = 5'($urandom_range(3, 15));

        for (phase = 0; phase < 10; phase++) begin
            set_length(phase_len[phase]);
            // phase 1 runs back to back with no sender gaps at all
            gaps = (phase != 1);

            // small pool so searches hit often; zero and all-ones always in it
            for (k = 0; k < 6; k++)
                pool[k] = $urandom;
            pool[6] = 32'hffff_ffff;
            pool[7] = 32'h0;

            // fill the used part of the list first so searches reach deep slots
            fill = (phase_len[phase] > DEPTH) ? DEPTH : int'(phase_len[phase]);
            sent = 0;
            for (k = 0; k < fill; k++) begin
                send(make_item(OP_LOAD, k[3:0], pool[$urandom_range(7)]));
                sent++;
            end

            while (sent < 85) begin
                roll = $urandom_range(99);
                if (roll < 5)
                    op = OP_NONE;
                else if (roll < 25)
                    op = OP_LOAD;
                else if (roll < 63)
                    op = OP_MTF;
                else
                    op = OP_TRANSPOSE;
                // mostly pool values (hits), sometimes anything (misses)
                v = ($urandom_range(99) < 80) ? pool[$urandom_range(7)] : $urandom;
                send(make_item(op, 4'($urandom_range(15)), v));
                if (op != OP_NONE)
                    sent++;
                if (gaps && $urandom_range(99) < 13)
                    pause($urandom_range(1, 3));
            end
        end

        // ---------------- wind down ----------------
        drain();
        repeat (4) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
